// ===== rtl/lcf_pkg.sv =====
// Shared types and constants for the linear convolution FIR block.
package lcf_pkg;

    localparam int VAL_W    = 16;   // Q1.15 sample / coefficient
    localparam int IDX_W    = 5;    // coefficient index field
    localparam int TAPCNT_W = 6;    // tap_count register
    localparam int PROD_W   = 32;   // Q2.30 product
    localparam int RES_W    = 40;   // accumulated result

    localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 6'd29;

    // command field codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // controls from the sequencer to the MAC datapath
    typedef struct packed {
        logic clear;    // zero the accumulator
        logic issue;    // operand pair valid this cycle
    } t_mac_ctl;

endpackage

// ===== rtl/lcf_in_if.sv =====
// Input command channel: valid/ready plus one command beat.
interface lcf_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [lcf_pkg::IDX_W-1:0]      coef_index;
    logic signed [lcf_pkg::VAL_W-1:0] value;
    logic                           block_end;

    modport source (output valid, command, coef_index, value, block_end, input ready);
    modport sink   (input valid, command, coef_index, value, block_end, output ready);
endinterface

// ===== rtl/lcf_out_if.sv =====
// Output result channel: valid/ready plus one result beat.
interface lcf_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [lcf_pkg::RES_W-1:0] result;
    logic                             last_result;

    modport source (output valid, result, last_result, input ready);
    modport sink   (input valid, result, last_result, output ready);
endinterface

// ===== rtl/lcf_cfg_if.sv =====
// Configuration write channel: valid/ready plus the tap_count write data.
interface lcf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcf_pkg::TAPCNT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/lcf_mac.sv =====
// Shared multiply-accumulate unit: registered product, then 40-bit accumulate.
module lcf_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lcf_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [lcf_pkg::VAL_W-1:0]   i_coef,
    input  logic signed [lcf_pkg::VAL_W-1:0]   i_sample,
    output logic                               o_busy,
    output logic signed [lcf_pkg::RES_W-1:0]   o_acc
);

    logic signed [lcf_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_vld;
    logic signed [lcf_pkg::RES_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + lcf_pkg::RES_W'(r_prod);
        end
    end

    assign o_busy = r_prod_vld;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/linear_convolution_fir_top.sv =====
// Top level of the streaming direct-form FIR (linear convolution) block.
//
// Usage:
//   i_in   : command beats. command LOAD writes value into tap coef_index
//            (ignored when coef_index >= TAPS, produces no result). command
//            SAMPLE pushes value into the delay line and produces one result.
//            A SAMPLE with block_end set also produces taps-1 tail results
//            (zeros pushed in); the final one carries last_result and the
//            delay line is cleared afterwards.
//   o_out  : result beats, Q10.30 sums in 40 bits.
//   i_cfg  : tap_count write (1..TAPS, 0 acts as 1, larger saturates).
//            Write only while the block is idle.
// Timing: a LOAD is taken whenever the block is idle. A SAMPLE drops
//   i_in.ready until its result and any tail results have been put into
//   the output register, so a new sample waits until the last one is done.
//   Each tail result reruns the MAC: one shared multiplier does one tap per cycle, plus
//   memory read, product, accumulate and put stages.
// Reset: tap_count returns to 29, coefficients and history read as zero.
// Stall: one output register; a finished result waits there while the next
//   sample is accepted and computed; the sequencer holds if it is still full.
module linear_convolution_fir_top #(
    parameter int TAPS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcf_in_if.sink    i_in,
    lcf_cfg_if.sink   i_cfg,
    lcf_out_if.source o_out
);

    localparam int AW = $clog2(TAPS);           // memory address width
    localparam int TW = $clog2(TAPS + 1);       // tap count width
    localparam int CW = (TW > lcf_pkg::TAPCNT_W) ? TW : lcf_pkg::TAPCNT_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [lcf_pkg::TAPCNT_W-1:0]     r_tap_count;
    logic [AW-1:0]                    r_head, n_head;
    logic [AW-1:0]                    r_j, n_j;
    logic [TW-1:0]                    r_tail, n_tail;
    logic                             r_end, n_end;

    // coefficient and history memories, with per-entry valid bits so that
    // unwritten/cleared entries read as zero
    logic signed [lcf_pkg::VAL_W-1:0] coef_mem [TAPS];
    logic signed [lcf_pkg::VAL_W-1:0] hist_mem [TAPS];
    logic [TAPS-1:0]                  r_cvalid;
    logic [TAPS-1:0]                  r_hvalid;

    logic signed [lcf_pkg::VAL_W-1:0] r_coef_rd, r_hist_rd;
    logic                             r_cv, r_hv, r_s1;

    logic                             r_out_valid;
    logic signed [lcf_pkg::RES_W-1:0] r_result;
    logic                             r_last;

    logic                             in_acc, in_sample, in_load, out_free;
    logic [TW-1:0]                    taps, taps_m1;
    logic [CW-1:0]                    tc_ext;
    logic [AW-1:0]                    head_inc, haddr, caddr;
    logic [AW:0]                      haddr_w;
    logic                             issue, last_issue;
    logic                             h_we;
    logic signed [lcf_pkg::VAL_W-1:0] h_wdata;
    logic                             clr_hist, put_out;
    lcf_pkg::t_mac_ctl                mac_ctl;
    logic                             mac_busy;
    logic signed [lcf_pkg::RES_W-1:0] mac_acc;

    // ---------------- handshakes ----------------
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc    = i_in.valid && i_in.ready;
    assign in_sample = in_acc && (i_in.command == lcf_pkg::CMD_SAMPLE);
    assign in_load   = in_acc && (i_in.command == lcf_pkg::CMD_LOAD);
    assign out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= lcf_pkg::TAPCNT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_tap_count <= i_cfg.data;
        end
    end

    // active taps: 0 acts as 1, saturate at TAPS
    always_comb begin
        tc_ext = CW'(r_tap_count);
        if (tc_ext == '0) begin
            taps = TW'(1);
        end else if (tc_ext > CW'(TAPS)) begin
            taps = TW'(TAPS);
        end else begin
            taps = TW'(tc_ext);
        end
        taps_m1 = taps - TW'(1);
    end

    // ---------------- addressing ----------------
    assign head_inc = (r_head == AW'(TAPS - 1)) ? '0 : r_head + AW'(1);
    // history entry j (0 = newest) lives at head - j, modulo TAPS
    assign haddr_w  = {1'b0, r_head} + ((r_head >= r_j) ? '0 : (AW+1)'(TAPS))
                      - {1'b0, r_j};
    assign haddr    = haddr_w[AW-1:0];
    assign caddr    = r_j;

    assign issue      = (r_state == S_MAC);
    assign last_issue = issue && (TW'(r_j) == taps_m1);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_j           = r_j;
        n_tail        = r_tail;
        n_end         = r_end;
        h_we          = 1'b0;
        h_wdata       = i_in.value;
        clr_hist      = 1'b0;
        put_out       = 1'b0;
        mac_ctl.clear = 1'b0;
        mac_ctl.issue = r_s1;
        case (r_state)
            S_IDLE: begin
                if (in_sample) begin
                    n_head        = head_inc;
                    h_we          = 1'b1;
                    n_j           = '0;
                    n_end         = i_in.block_end;
                    n_tail        = i_in.block_end ? taps_m1 : '0;
                    mac_ctl.clear = 1'b1;
                    n_state       = S_MAC;
                end
            end
            S_MAC: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_s1 && !mac_busy) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    put_out = 1'b1;
                    if (r_end && (r_tail != '0)) begin
                        // tail output: push a zero and run again
                        n_head        = head_inc;
                        h_we          = 1'b1;
                        h_wdata       = '0;
                        n_tail        = r_tail - TW'(1);
                        n_j           = '0;
                        mac_ctl.clear = 1'b1;
                        n_state       = S_MAC;
                    end else begin
                        clr_hist = r_end;
                        n_end    = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_j     <= '0;
            r_tail  <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_j     <= n_j;
            r_tail  <= n_tail;
            r_end   <= n_end;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (in_load && (32'(i_in.coef_index) < TAPS)) begin
            coef_mem[AW'(i_in.coef_index)] <= i_in.value;
        end
        r_coef_rd <= coef_mem[caddr];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hist_mem[n_head] <= h_wdata;
        end
        r_hist_rd <= hist_mem[haddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_hvalid <= '0;
            r_cv     <= 1'b0;
            r_hv     <= 1'b0;
            r_s1     <= 1'b0;
        end else begin
            if (in_load && (32'(i_in.coef_index) < TAPS)) begin
                r_cvalid[AW'(i_in.coef_index)] <= 1'b1;
            end
            if (clr_hist) begin
                r_hvalid <= '0;
            end else if (h_we) begin
                r_hvalid[n_head] <= 1'b1;
            end
            r_cv <= r_cvalid[caddr];
            r_hv <= r_hvalid[haddr];
            r_s1 <= issue;
        end
    end

    // ---------------- MAC ----------------
    lcf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_coef   (r_cv ? r_coef_rd : '0),
        .i_sample (r_hv ? r_hist_rd : '0),
        .o_busy   (mac_busy),
        .o_acc    (mac_acc)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (put_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_out) begin
            r_result <= mac_acc;
            r_last   <= r_end && (r_tail == '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result      = r_result;
    assign o_out.last_result = r_last;

    // ---------------- assertions ----------------
    a_tail_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail != '0) |-> r_end)
        else $error("tail count pending outside a block end");

    a_idle_no_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1 && !mac_busy))
        else $error("MAC pipeline busy while idle");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_sample |=> (r_state == S_MAC))
        else $error("accepted sample did not start MAC");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_out && r_end && (r_tail == '0)) |=> (r_hvalid == '0))
        else $error("history not cleared after final output");

endmodule
